>>> sv/dcf_pkg.sv
// Shared types, codes and constants for the DCF frame-exchange sequencer.
// No dependencies; compiled first.
`default_nettype none

package dcf_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam logic [23:0] DEFAULT_TIMEOUT_US = 24'd100000;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_WT_TRIG = 4'd1,
    ST_WT_RESP = 4'd2,
    ST_TX_TRIG = 4'd3,
    ST_TX_RESP = 4'd4,
    ST_WT_CTS  = 4'd5,
    ST_WT_ACK  = 4'd6,
    ST_TX_CTS  = 4'd7,
    ST_TX_ACK  = 4'd8
  } state_t;

  localparam logic [2:0] KIND_NEW   = 3'd0;
  localparam logic [2:0] KIND_RX    = 3'd1;
  localparam logic [2:0] KIND_DONE  = 3'd2;
  localparam logic [2:0] KIND_TIMER = 3'd3;
  localparam logic [2:0] KIND_POLL  = 3'd4;

  localparam logic [2:0] FT_RTS  = 3'd0;
  localparam logic [2:0] FT_CTS  = 3'd1;
  localparam logic [2:0] FT_DATA = 3'd2;
  localparam logic [2:0] FT_ACK  = 3'd3;

  localparam logic [3:0] ACT_NONE     = 4'd0;
  localparam logic [3:0] ACT_TRIGGER  = 4'd1;
  localparam logic [3:0] ACT_CTS      = 4'd2;
  localparam logic [3:0] ACT_DATA     = 4'd3;
  localparam logic [3:0] ACT_ACK      = 4'd4;
  localparam logic [3:0] ACT_SUCCESS  = 4'd5;
  localparam logic [3:0] ACT_DROP     = 4'd6;
  localparam logic [3:0] ACT_CCA_BUSY = 4'd7;
  localparam logic [3:0] ACT_CCA_IDLE = 4'd8;

  localparam logic [1:0] REG_FIXED_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_NOTIFIER      = 2'd1;
  localparam logic [1:0] REG_RETRY_LIMIT   = 2'd2;

  typedef struct packed {
    logic [23:0] fixed_timeout_us;
    logic        notifier_present;
    logic [3:0]  retry_limit;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  action;
    logic        timer_start;
    logic [23:0] timer_value_us;
    state_t      fsm_state;
  } res_t;

  typedef struct packed {
    res_t [2:0] res;
    logic [1:0] cnt;
  } bundle_t;

endpackage

`default_nettype wire

>>> sv/dcf_if.sv
// Valid/ready channel interfaces for event beats in and result beats out.
// Depends on nothing but the field widths of dcf_pkg's codes.
`default_nettype none

interface dcf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [2:0]  frame_type;
  logic        dest_unicast;
  logic        wants_rts;
  logic        downstream_ready;
  logic [23:0] exact_timeout_us;

  modport source (output valid, kind, frame_type, dest_unicast, wants_rts,
                  downstream_ready, exact_timeout_us, input ready);
  modport sink (input valid, kind, frame_type, dest_unicast, wants_rts,
                downstream_ready, exact_timeout_us, output ready);
endinterface

interface dcf_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic        timer_start;
  logic [23:0] timer_value_us;
  logic [3:0]  fsm_state;
  logic        last;

  modport source (output valid, action, timer_start, timer_value_us, fsm_state, last,
                  input ready);
  modport sink (input valid, action, timer_start, timer_value_us, fsm_state, last,
                output ready);
endinterface

`default_nettype wire

>>> sv/dcf_front.sv
// Front end: accepts event beats, runs the exchange state machine and
// builds the result bundle of each event. Depends on dcf_pkg, dcf_in_if.
`default_nettype none

module dcf_front (
  input  wire logic            clk,
  input  wire logic            rst,
  dcf_in_if.sink               in_ch,
  input  wire dcf_pkg::cfg_t   cfg,
  input  wire logic            full,
  output logic                 push,
  output dcf_pkg::bundle_t     push_data
);
  import dcf_pkg::*;

  typedef struct packed {
    state_t      cur;
    state_t      prev;
    logic        regard_lost;
    logic [3:0]  retry_count;
    logic        has_response;
    logic        trigger_pending;
    logic        trigger_broadcast;
    logic [23:0] pending_timeout;
  } ctx_t;

  typedef struct packed {
    ctx_t       s;
    res_t [2:0] res;
    logic [1:0] cnt;
  } work_t;

  ctx_t  ctx;
  work_t w;
  logic  accept;

  function automatic logic [23:0] timeout_now(input state_t cur, input logic bcast,
                                              input cfg_t c, input logic [23:0] exact);
    logic [23:0] t;
    if (c.fixed_timeout_us != 24'd0) begin
      if ((cur == ST_WT_TRIG && bcast) || cur == ST_WT_ACK) begin
        t = 24'd0;
      end else if (cur == ST_WT_TRIG || cur == ST_WT_CTS || cur == ST_WT_RESP) begin
        t = c.fixed_timeout_us;
      end else begin
        t = 24'd0;
      end
    end else if (c.notifier_present) begin
      t = exact;
    end else begin
      t = DEFAULT_TIMEOUT_US;
    end
    return t;
  endfunction

  function automatic void emit(inout work_t x, input logic [3:0] act, input logic ts,
                               input logic [23:0] tv, input state_t st);
    if (x.cnt != 2'd3) begin
      x.res[x.cnt].action         = act;
      x.res[x.cnt].timer_start    = ts;
      x.res[x.cnt].timer_value_us = ts ? tv : 24'd0;
      x.res[x.cnt].fsm_state      = st;
      x.cnt = x.cnt + 2'd1;
    end
  endfunction

  function automatic void send_frame(inout work_t x, input logic [3:0] act,
                                     input state_t tx, input cfg_t c,
                                     input logic [23:0] exact);
    x.s.pending_timeout = timeout_now(x.s.cur, x.s.trigger_broadcast, c, exact);
    if (!c.notifier_present) begin
      x.s.cur = tx;
      emit(x, act, 1'b1, x.s.pending_timeout, x.s.cur);
    end else begin
      emit(x, act, 1'b0, 24'd0, x.s.cur);
    end
  endfunction

  function automatic void send_trigger(inout work_t x, input cfg_t c,
                                       input logic [23:0] exact);
    x.s.trigger_pending = 1'b0;
    send_frame(x, ACT_TRIGGER, ST_TX_TRIG, c, exact);
  endfunction

  function automatic void go_idle(inout work_t x, input logic [3:0] act);
    x.s.cur             = ST_IDLE;
    x.s.has_response    = 1'b0;
    x.s.trigger_pending = 1'b0;
    x.s.retry_count     = 4'd0;
    emit(x, act, 1'b0, 24'd0, x.s.cur);
  endfunction

  always_comb begin
    logic        rdy;
    logic [2:0]  ft;
    logic [23:0] ex;
    logic        done_hit;
    state_t      done_next;
    rdy       = in_ch.downstream_ready;
    ft        = in_ch.frame_type;
    ex        = in_ch.exact_timeout_us;
    done_hit  = 1'b0;
    done_next = ST_IDLE;
    w.s   = ctx;
    w.res = '0;
    w.cnt = 2'd0;
    case (in_ch.kind)
      KIND_NEW, KIND_POLL: begin
        if (w.s.cur == ST_WT_TRIG && w.s.trigger_pending && rdy) begin
          send_trigger(w, cfg, ex);
        end else if (in_ch.kind == KIND_NEW && w.s.cur == ST_IDLE) begin
          w.s.trigger_broadcast = !in_ch.dest_unicast;
          w.s.has_response      = in_ch.dest_unicast && in_ch.wants_rts;
          w.s.retry_count       = 4'd0;
          w.s.cur               = ST_WT_TRIG;
          if (rdy) begin
            send_trigger(w, cfg, ex);
          end else begin
            w.s.trigger_pending = 1'b1;
            emit(w, ACT_NONE, 1'b0, 24'd0, w.s.cur);
          end
        end
      end
      KIND_RX: begin
        if (ft == FT_RTS && (w.s.cur == ST_IDLE || w.s.cur == ST_WT_TRIG)) begin
          w.s.prev = w.s.cur;
          w.s.cur  = ST_WT_CTS;
          emit(w, ACT_CCA_BUSY, 1'b0, 24'd0, w.s.cur);
          send_frame(w, ACT_CTS, ST_TX_CTS, cfg, ex);
        end else if (ft == FT_CTS && w.s.cur == ST_TX_TRIG) begin
          if (w.s.has_response) begin
            w.s.cur = ST_WT_RESP;
            send_frame(w, ACT_DATA, ST_TX_RESP, cfg, ex);
          end
        end else if (ft == FT_DATA && (w.s.cur == ST_TX_CTS || w.s.cur == ST_IDLE ||
                                       w.s.cur == ST_WT_TRIG)) begin
          if (w.s.cur != ST_TX_CTS) w.s.prev = w.s.cur;
          w.s.cur = ST_WT_ACK;
          emit(w, ACT_CCA_BUSY, 1'b0, 24'd0, w.s.cur);
          send_frame(w, ACT_ACK, ST_TX_ACK, cfg, ex);
        end else if (ft == FT_ACK && (w.s.cur == ST_TX_RESP ||
                                      (w.s.cur == ST_TX_TRIG && !w.s.has_response))) begin
          go_idle(w, ACT_SUCCESS);
        end
      end
      KIND_DONE: begin
        if (cfg.notifier_present) begin
          if ((ft == FT_RTS || ft == FT_DATA) && w.s.cur == ST_WT_TRIG) begin
            done_hit = 1'b1; done_next = ST_TX_TRIG;
          end else if (ft == FT_CTS && w.s.cur == ST_WT_CTS) begin
            done_hit = 1'b1; done_next = ST_TX_CTS;
          end else if (ft == FT_DATA && w.s.cur == ST_WT_RESP) begin
            done_hit = 1'b1; done_next = ST_TX_RESP;
          end else if (ft == FT_ACK && w.s.cur == ST_WT_ACK) begin
            done_hit = 1'b1; done_next = ST_TX_ACK;
          end else if ((ft == FT_RTS || ft == FT_DATA) && w.s.cur == ST_WT_CTS) begin
            w.s.regard_lost = 1'b1;
          end
          if (done_hit) begin
            w.s.cur = done_next;
            emit(w, ACT_NONE, 1'b1, w.s.pending_timeout, w.s.cur);
          end
        end
      end
      KIND_TIMER: begin
        if (w.s.cur == ST_TX_TRIG || w.s.cur == ST_TX_RESP) begin
          if (!w.s.trigger_broadcast && w.s.retry_count < cfg.retry_limit) begin
            w.s.retry_count = w.s.retry_count + 4'd1;
            w.s.cur         = ST_WT_TRIG;
            if (rdy) begin
              send_trigger(w, cfg, ex);
            end else begin
              w.s.trigger_pending = 1'b1;
              emit(w, ACT_NONE, 1'b0, 24'd0, w.s.cur);
            end
          end else begin
            go_idle(w, ACT_DROP);
          end
        end else if (w.s.cur == ST_TX_CTS || w.s.cur == ST_TX_ACK) begin
          emit(w, ACT_CCA_IDLE, 1'b0, 24'd0, w.s.cur);
          if (w.s.prev == ST_WT_TRIG && w.s.regard_lost) begin
            w.s.prev        = ST_TX_TRIG;
            w.s.regard_lost = 1'b0;
          end
          if (w.s.prev == ST_WT_TRIG) begin
            w.s.cur = ST_WT_TRIG;
            w.s.pending_timeout = timeout_now(w.s.cur, w.s.trigger_broadcast, cfg, ex);
            if (w.s.trigger_pending && rdy) begin
              send_trigger(w, cfg, ex);
            end else begin
              emit(w, ACT_NONE, 1'b0, 24'd0, w.s.cur);
            end
          end else if (w.s.prev == ST_TX_TRIG) begin
            w.s.cur = ST_TX_TRIG;
            emit(w, ACT_NONE, 1'b1, 24'd0, w.s.cur);
          end else begin
            w.s.cur = ST_IDLE;
            emit(w, ACT_NONE, 1'b0, 24'd0, w.s.cur);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ch.ready   = !full;
  assign accept        = in_ch.valid && in_ch.ready;
  assign push          = accept && (w.cnt != 2'd0);
  assign push_data.res = w.res;
  assign push_data.cnt = w.cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.cur               <= ST_IDLE;
      ctx.prev              <= ST_IDLE;
      ctx.regard_lost       <= 1'b0;
      ctx.retry_count       <= 4'd0;
      ctx.has_response      <= 1'b0;
      ctx.trigger_pending   <= 1'b0;
      ctx.trigger_broadcast <= 1'b0;
      ctx.pending_timeout   <= 24'd0;
    end else if (accept) begin
      ctx <= w.s;
    end
  end

endmodule

`default_nettype wire

>>> sv/dcf_queue.sv
// Bundle queue between front and back ends.
// Depends on dcf_pkg for the bundle type.
`default_nettype none

module dcf_queue #(
  parameter int unsigned DEPTH = dcf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire dcf_pkg::bundle_t  push_data,
  input  wire logic              pop,
  output dcf_pkg::bundle_t       head,
  output logic                   empty,
  output logic                   full,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import dcf_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bundle_t            slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic               do_push;
  logic               do_pop;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/dcf_back.sv
// Back end: unpacks each bundle into result beats on the output channel.
// Depends on dcf_pkg, dcf_out_if.
`default_nettype none

module dcf_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dcf_pkg::bundle_t  head,
  input  wire logic              empty,
  output logic                   pop,
  output logic                   busy,
  dcf_out_if.source              out_ch
);
  import dcf_pkg::*;

  bundle_t    cur;
  logic [1:0] idx;
  logic       fire;
  logic       is_last;
  res_t       r;

  assign r       = cur.res[idx];
  assign is_last = (idx == cur.cnt - 2'd1);
  assign fire    = out_ch.valid && out_ch.ready;
  assign pop     = !empty && (!busy || (fire && is_last));

  assign out_ch.valid          = busy;
  assign out_ch.action         = r.action;
  assign out_ch.timer_start    = r.timer_start;
  assign out_ch.timer_value_us = r.timer_value_us;
  assign out_ch.fsm_state      = r.fsm_state;
  assign out_ch.last           = is_last;

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (fire && is_last) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (fire) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

`default_nettype wire

>>> sv/dcf_frame_exchange_fsm.sv
// Top level of the DCF frame-exchange sequencer: config registers, front end,
// bundle queue and back end. Depends on dcf_pkg, dcf_if, dcf_front, dcf_queue, dcf_back.
`default_nettype none

// One event beat is accepted per clock; the front end resolves the whole
// transition in that cycle and hands its zero to three result beats to a
// bundle queue of QUEUE_DEPTH entries. The back end sends one result beat
// per cycle while out_ch.ready is high, and the input stalls only while
// the bundle queue is full. An accepted event's bundle passes through a
// queue slot and then the back end's cur register to its first result beat.
// Events that produce no result leave the queue untouched.
// Configuration: fixed_timeout_us at 0x0, notifier_present at 0x4,
// retry_limit at 0x8; pready is tied high.
module dcf_frame_exchange_fsm #(
  parameter int unsigned QUEUE_DEPTH = dcf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  dcf_in_if.sink           in_ch,
  dcf_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import dcf_pkg::*;

  cfg_t                              cfg;
  logic                              push;
  bundle_t                           push_data;
  bundle_t                           head;
  logic                              q_empty;
  logic                              q_full;
  logic [$clog2(QUEUE_DEPTH+1)-1:0]  q_count;
  logic                              pop;
  logic                              busy;
  logic                              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fixed_timeout_us <= 24'd0;
      cfg.notifier_present <= 1'b0;
      cfg.retry_limit      <= 4'd7;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_FIXED_TIMEOUT: cfg.fixed_timeout_us <= pwdata[23:0];
        REG_NOTIFIER:      cfg.notifier_present <= pwdata[0];
        REG_RETRY_LIMIT:   cfg.retry_limit      <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FIXED_TIMEOUT: prdata = {8'd0, cfg.fixed_timeout_us};
      REG_NOTIFIER:      prdata = {31'd0, cfg.notifier_present};
      REG_RETRY_LIMIT:   prdata = {28'd0, cfg.retry_limit};
      default:           prdata = 32'd0;
    endcase
  end

  dcf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .full      (q_full),
    .push      (push),
    .push_data (push_data)
  );

  dcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full),
    .count     (q_count)
  );

  dcf_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .busy   (busy),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push |=> (q_count != '0) || busy)
    else $error("pushed bundle vanished");

  a_drain_stops: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.last && q_empty && !push) |=> !out_ch.valid)
    else $error("result beat after bundle drained");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("queue count overflow");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for dcf_frame_exchange_fsm: directed DCF exchanges, then random
// event streams under several register settings, checked against an in-bench exchange model.
// Depends on dcf_pkg, dcf_if and the RTL of the block.
`timescale 1ns / 100ps

module tb;
  import dcf_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD = 100;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_EVENTS = 40;

  typedef struct {
    logic [2:0]  kind;
    logic [2:0]  frame_type;
    logic        dest_unicast;
    logic        wants_rts;
    logic        downstream_ready;
    logic [23:0] exact_timeout_us;
  } dcf_event_t;

  typedef struct {
    logic [3:0]  action;
    logic        timer_start;
    logic [23:0] timer_value_us;
    logic [3:0]  fsm_state;
    logic        last;
  } exchange_beat_t;

  // Tracks the exchange state and holds the result beats still owed by the block.
  class exchange_tracker;
    logic [23:0] fixed_to;
    logic        notif;
    logic [3:0]  rlimit;
    state_t      cur_state;
    state_t      prev_state;
    logic        regard_lost;
    logic [3:0]  retry_count;
    logic        has_response;
    logic        trigger_pending;
    logic        trigger_broadcast;
    logic [23:0] pending_timeout;
    logic [23:0] exact_in;
    exchange_beat_t owed_beats[$];
    exchange_beat_t step_beats[$];
    int unsigned errors;
    int unsigned events_seen;
    int unsigned beats_seen;

    function new();
      fixed_to = '0;
      notif = 1'b0;
      rlimit = 4'd7;
      cur_state = ST_IDLE;
      prev_state = ST_IDLE;
      regard_lost = 1'b0;
      retry_count = '0;
      has_response = 1'b0;
      trigger_pending = 1'b0;
      trigger_broadcast = 1'b0;
      pending_timeout = '0;
      exact_in = '0;
      errors = 0;
      events_seen = 0;
      beats_seen = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_FIXED_TIMEOUT: fixed_to = val[23:0];
        REG_NOTIFIER:      notif = val[0];
        REG_RETRY_LIMIT:   rlimit = val[3:0];
        default: ;
      endcase
    endfunction

    function void push_beat(logic [3:0] act, logic ts, logic [23:0] tv);
      exchange_beat_t b;
      if (step_beats.size() >= 3) return;
      b.action = act;
      b.timer_start = ts;
      b.timer_value_us = ts ? tv : 24'd0;
      b.fsm_state = cur_state;
      b.last = 1'b0;
      step_beats.push_back(b);
    endfunction

    function logic [23:0] timeout_for_send();
      if (fixed_to != 0) begin
        if ((cur_state == ST_WT_TRIG && trigger_broadcast) || cur_state == ST_WT_ACK)
          return 24'd0;
        if (cur_state == ST_WT_TRIG || cur_state == ST_WT_CTS || cur_state == ST_WT_RESP)
          return fixed_to;
        return 24'd0;
      end
      if (notif) return exact_in;
      return DEFAULT_TIMEOUT_US;
    endfunction

    // without a notifier the frame counts as sent at once
    function void send_frame(logic [3:0] act, state_t tx_state);
      pending_timeout = timeout_for_send();
      if (!notif) begin
        cur_state = tx_state;
        push_beat(act, 1'b1, pending_timeout);
      end else begin
        push_beat(act, 1'b0, 24'd0);
      end
    endfunction

    function void send_trigger();
      trigger_pending = 1'b0;
      send_frame(ACT_TRIGGER, ST_TX_TRIG);
    endfunction

    function void go_idle(logic [3:0] act);
      cur_state = ST_IDLE;
      has_response = 1'b0;
      trigger_pending = 1'b0;
      retry_count = '0;
      push_beat(act, 1'b0, 24'd0);
    endfunction

    function void rx_frame(logic [2:0] ft);
      if (ft == FT_RTS && (cur_state == ST_IDLE || cur_state == ST_WT_TRIG)) begin
        prev_state = cur_state;
        cur_state = ST_WT_CTS;
        push_beat(ACT_CCA_BUSY, 1'b0, 24'd0);
        send_frame(ACT_CTS, ST_TX_CTS);
      end else if (ft == FT_CTS && cur_state == ST_TX_TRIG) begin
        if (has_response) begin
          cur_state = ST_WT_RESP;
          send_frame(ACT_DATA, ST_TX_RESP);
        end
      end else if (ft == FT_DATA && (cur_state == ST_TX_CTS || cur_state == ST_IDLE ||
                                     cur_state == ST_WT_TRIG)) begin
        if (cur_state != ST_TX_CTS) prev_state = cur_state;
        cur_state = ST_WT_ACK;
        push_beat(ACT_CCA_BUSY, 1'b0, 24'd0);
        send_frame(ACT_ACK, ST_TX_ACK);
      end else if (ft == FT_ACK && (cur_state == ST_TX_RESP ||
                                    (cur_state == ST_TX_TRIG && !has_response))) begin
        go_idle(ACT_SUCCESS);
      end
    endfunction

    function void tx_done(logic [2:0] ft);
      state_t nxt;
      bit     hit;
      if (!notif) return;
      hit = 1'b1;
      nxt = cur_state;
      if (ft == FT_RTS && cur_state == ST_WT_TRIG) nxt = ST_TX_TRIG;
      else if (ft == FT_CTS && cur_state == ST_WT_CTS) nxt = ST_TX_CTS;
      else if (ft == FT_DATA && cur_state == ST_WT_TRIG) nxt = ST_TX_TRIG;
      else if (ft == FT_DATA && cur_state == ST_WT_RESP) nxt = ST_TX_RESP;
      else if (ft == FT_ACK && cur_state == ST_WT_ACK) nxt = ST_TX_ACK;
      else begin
        hit = 1'b0;
        if ((ft == FT_RTS || ft == FT_DATA) && cur_state == ST_WT_CTS) regard_lost = 1'b1;
      end
      if (hit) begin
        cur_state = nxt;
        push_beat(ACT_NONE, 1'b1, pending_timeout);
      end
    endfunction

    function void timer_expiry(logic ready);
      if (cur_state == ST_TX_TRIG || cur_state == ST_TX_RESP) begin
        if (!trigger_broadcast && retry_count < rlimit) begin
          retry_count = retry_count + 4'd1;
          cur_state = ST_WT_TRIG;
          if (ready) send_trigger();
          else begin
            trigger_pending = 1'b1;
            push_beat(ACT_NONE, 1'b0, 24'd0);
          end
        end else begin
          go_idle(ACT_DROP);
        end
      end else if (cur_state == ST_TX_CTS || cur_state == ST_TX_ACK) begin
        push_beat(ACT_CCA_IDLE, 1'b0, 24'd0);
        if (prev_state == ST_WT_TRIG && regard_lost) begin
          prev_state = ST_TX_TRIG;
          regard_lost = 1'b0;
        end
        if (prev_state == ST_WT_TRIG) begin
          cur_state = ST_WT_TRIG;
          pending_timeout = timeout_for_send();
          if (trigger_pending && ready) send_trigger();
          else push_beat(ACT_NONE, 1'b0, 24'd0);
        end else if (prev_state == ST_TX_TRIG) begin
          cur_state = ST_TX_TRIG;
          push_beat(ACT_NONE, 1'b1, 24'd0);
        end else begin
          cur_state = ST_IDLE;
          push_beat(ACT_NONE, 1'b0, 24'd0);
        end
      end
    endfunction

    function void note_event(dcf_event_t ev);
      step_beats.delete();
      exact_in = ev.exact_timeout_us;
      events_seen++;
      case (ev.kind)
        KIND_NEW, KIND_POLL: begin
          if (cur_state == ST_WT_TRIG && trigger_pending && ev.downstream_ready) begin
            send_trigger();
          end else if (ev.kind == KIND_NEW && cur_state == ST_IDLE) begin
            trigger_broadcast = !ev.dest_unicast;
            has_response = ev.dest_unicast && ev.wants_rts;
            retry_count = '0;
            cur_state = ST_WT_TRIG;
            if (ev.downstream_ready) send_trigger();
            else begin
              trigger_pending = 1'b1;
              push_beat(ACT_NONE, 1'b0, 24'd0);
            end
          end
        end
        KIND_RX:    rx_frame(ev.frame_type);
        KIND_DONE:  tx_done(ev.frame_type);
        KIND_TIMER: timer_expiry(ev.downstream_ready);
        default: ;
      endcase
      if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
      foreach (step_beats[i]) owed_beats.push_back(step_beats[i]);
    endfunction

    function void flag_field(string name, logic [31:0] want, logic [31:0] seen);
      errors++;
      $display("%0t ERROR %s mismatch: expected %0d, got %0d", $time, name, want, seen);
    endfunction

    function void check_beat(exchange_beat_t got);
      exchange_beat_t want;
      if (owed_beats.size() == 0) begin
        errors++;
        $display("%0t ERROR unexpected result beat: expected none, got action %0d state %0d",
                 $time, got.action, got.fsm_state);
        return;
      end
      want = owed_beats.pop_front();
      beats_seen++;
      if (got.action !== want.action) flag_field("action", want.action, got.action);
      if (got.timer_start !== want.timer_start)
        flag_field("timer_start", want.timer_start, got.timer_start);
      if (got.timer_value_us !== want.timer_value_us)
        flag_field("timer_value_us", want.timer_value_us, got.timer_value_us);
      if (got.fsm_state !== want.fsm_state)
        flag_field("fsm_state", want.fsm_state, got.fsm_state);
      if (got.last !== want.last) flag_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dcf_in_if  in_ch();
  dcf_out_if out_ch();

  exchange_tracker sb;
  bit          in_steady;
  bit          out_steady;
  bit          long_hold_req;
  int unsigned stall_left;
  int unsigned idle_cycles;
  int unsigned settings_used;

  dcf_frame_exchange_fsm dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic dcf_event_t random_fields();
    dcf_event_t ev;
    int unsigned r;
    ev.kind = 3'($urandom_range(0, 7));
    ev.frame_type = 3'($urandom_range(0, 7));
    ev.dest_unicast = ($urandom_range(0, 3) != 0);
    ev.wants_rts = 1'($urandom_range(0, 1));
    ev.downstream_ready = ($urandom_range(0, 3) != 0);
    r = $urandom_range(0, 9);
    if (r == 0) ev.exact_timeout_us = 24'd0;
    else if (r == 1) ev.exact_timeout_us = 24'hFFFFFF;
    else ev.exact_timeout_us = 24'($urandom());
    return ev;
  endfunction

  // mostly events that move the current exchange on, the rest noise
  function automatic dcf_event_t pick_event();
    dcf_event_t  ev;
    int unsigned pick;
    logic [5:0]  kf;
    ev = random_fields();
    if ($urandom_range(0, 99) < 20) return ev;
    pick = $urandom_range(0, 3);
    case (sb.cur_state)
      ST_IDLE:    kf = (pick < 2) ? {KIND_NEW, FT_DATA} :
                       (pick == 2) ? {KIND_RX, FT_RTS} : {KIND_RX, FT_DATA};
      ST_WT_TRIG: kf = (pick == 0) ? {KIND_POLL, FT_DATA} :
                       (pick == 1) ? {KIND_DONE, ev.wants_rts ? FT_RTS : FT_DATA} :
                       (pick == 2) ? {KIND_RX, FT_RTS} : {KIND_RX, FT_DATA};
      ST_TX_TRIG: kf = (pick == 0) ? {KIND_RX, FT_CTS} :
                       (pick == 1) ? {KIND_RX, FT_ACK} : {KIND_TIMER, FT_ACK};
      ST_WT_RESP: kf = (pick < 3) ? {KIND_DONE, FT_DATA} : {KIND_TIMER, FT_DATA};
      ST_TX_RESP: kf = (pick < 2) ? {KIND_RX, FT_ACK} : {KIND_TIMER, FT_ACK};
      ST_WT_CTS:  kf = (pick < 2) ? {KIND_DONE, FT_CTS} :
                       (pick == 2) ? {KIND_DONE, FT_RTS} : {KIND_DONE, FT_DATA};
      ST_WT_ACK:  kf = (pick < 3) ? {KIND_DONE, FT_ACK} : {KIND_RX, FT_ACK};
      ST_TX_CTS:  kf = (pick < 2) ? {KIND_RX, FT_DATA} : {KIND_TIMER, FT_DATA};
      ST_TX_ACK:  kf = (pick < 3) ? {KIND_TIMER, FT_ACK} : {KIND_RX, FT_CTS};
      default:    kf = {ev.kind, ev.frame_type};
    endcase
    {ev.kind, ev.frame_type} = kf;
    return ev;
  endfunction

  task automatic offer_event(input dcf_event_t ev);
    int unsigned gap;
    gap = in_steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= ev.kind;
    in_ch.frame_type <= ev.frame_type;
    in_ch.dest_unicast <= ev.dest_unicast;
    in_ch.wants_rts <= ev.wants_rts;
    in_ch.downstream_ready <= ev.downstream_ready;
    in_ch.exact_timeout_us <= ev.exact_timeout_us;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_event(ev);
  endtask

  task automatic offer(input logic [2:0] k, input logic [2:0] f, input logic u,
                       input logic r, input logic d, input logic [23:0] x);
    dcf_event_t ev;
    ev.kind = k;
    ev.frame_type = f;
    ev.dest_unicast = u;
    ev.wants_rts = r;
    ev.downstream_ready = d;
    ev.exact_timeout_us = x;
    offer_event(ev);
  endtask

  // wait for every owed beat, then give unanswered events time to clear the pipe
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (sb.owed_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // drive wait states of the exchange to a state the next setting can leave
  task automatic settle_exchange();
    dcf_event_t ev;
    for (int n = 0; n < 4; n++) begin
      ev = random_fields();
      ev.kind = KIND_DONE;
      ev.downstream_ready = 1'b1;
      case (sb.cur_state)
        ST_WT_TRIG: begin
          if (sb.trigger_pending) ev.kind = KIND_POLL;
          else ev.frame_type = FT_RTS;
        end
        ST_WT_RESP: ev.frame_type = FT_DATA;
        ST_WT_CTS:  ev.frame_type = FT_CTS;
        ST_WT_ACK:  ev.frame_type = FT_ACK;
        default:    return;
      endcase
      offer_event(ev);
    end
  endtask

  // result sink: random stalls, steady stretches, and one long hold-off on request
  always @(posedge clk) begin
    exchange_beat_t got;
    int unsigned    g;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        got.action = out_ch.action;
        got.timer_start = out_ch.timer_start;
        got.timer_value_us = out_ch.timer_value_us;
        got.fsm_state = out_ch.fsm_state;
        got.last = out_ch.last;
        sb.check_beat(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else begin
        g = out_steady ? 0 : pick_gap();
        if (g != 0) begin
          stall_left = g - 1;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    logic [23:0] fix_tab [5];
    logic        notif_tab [5];
    logic [3:0]  lim_tab [5];
    sb = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_NEW;
    in_ch.frame_type = FT_RTS;
    in_ch.dest_unicast = 1'b0;
    in_ch.wants_rts = 1'b0;
    in_ch.downstream_ready = 1'b0;
    in_ch.exact_timeout_us = '0;
    out_ch.ready = 1'b0;
    in_steady = 1'b0;
    out_steady = 1'b0;
    long_hold_req = 1'b0;
    stall_left = 0;
    settings_used = 1;
    fix_tab = '{24'd0, 24'hFFFFFF, 24'd1, 24'($urandom_range(2, 24'hFFFFFE)), 24'd0};
    notif_tab = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    lim_tab = '{4'd0, 4'd15, 4'd3, 4'($urandom_range(1, 14)), 4'd7};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: frames count as sent on emission
    offer(KIND_NEW, FT_RTS, 1'b0, 1'b1, 1'b1, 24'hFFFFFF);   // broadcast trigger
    offer(KIND_TIMER, FT_RTS, 1'b0, 1'b0, 1'b1, 24'd0);      // broadcast expiry: drop
    offer(KIND_NEW, FT_DATA, 1'b1, 1'b1, 1'b0, 24'd0);       // RTS-first, queue not ready
    offer(KIND_NEW, FT_DATA, 1'b1, 1'b0, 1'b0, 24'd5);       // refused outside idle
    offer(KIND_POLL, FT_DATA, 1'b0, 1'b0, 1'b1, 24'd0);      // held trigger goes out
    offer(KIND_RX, FT_CTS, 1'b0, 1'b0, 1'b0, 24'd0);         // CTS -> data
    offer(KIND_TIMER, FT_RTS, 1'b0, 1'b0, 1'b0, 24'd0);      // retry, not ready
    offer(3'd5, FT_RTS, 1'b1, 1'b1, 1'b1, 24'hFFFFFF);       // unknown kinds
    offer(3'd7, 3'd7, 1'b1, 1'b1, 1'b1, 24'hFFFFFF);
    offer(KIND_RX, 3'd7, 1'b0, 1'b0, 1'b0, 24'd0);           // unknown frame type
    offer(KIND_POLL, FT_RTS, 1'b0, 1'b0, 1'b1, 24'd0);
    offer(KIND_RX, FT_CTS, 1'b0, 1'b0, 1'b0, 24'd0);
    offer(KIND_RX, FT_ACK, 1'b0, 1'b0, 1'b0, 24'd0);         // success
    offer(KIND_NEW, FT_DATA, 1'b1, 1'b0, 1'b1, 24'd0);       // plain unicast
    offer(KIND_RX, FT_CTS, 1'b0, 1'b0, 1'b0, 24'd0);         // CTS with no data pending
    offer(KIND_RX, FT_ACK, 1'b0, 1'b0, 1'b0, 24'd0);
    offer(KIND_RX, FT_RTS, 1'b0, 1'b0, 1'b0, 24'd0);         // respond with CTS
    offer(KIND_RX, FT_DATA, 1'b0, 1'b0, 1'b0, 24'd0);        // respond with ACK
    offer(KIND_TIMER, FT_DATA, 1'b0, 1'b0, 1'b0, 24'd0);
    offer(KIND_DONE, FT_RTS, 1'b0, 1'b0, 1'b0, 24'd0);       // done ignored w/o notifier
    quiesce();

    // notifier present: lost trigger during a CTS response
    write_reg(REG_NOTIFIER, 32'd1);
    settings_used++;
    offer(KIND_NEW, FT_DATA, 1'b1, 1'b1, 1'b1, 24'h123456);
    offer(KIND_RX, FT_RTS, 1'b0, 1'b0, 1'b0, 24'h00ABCD);
    offer(KIND_DONE, FT_RTS, 1'b0, 1'b0, 1'b0, 24'd0);
    offer(KIND_DONE, FT_CTS, 1'b0, 1'b0, 1'b0, 24'd0);
    offer(KIND_TIMER, FT_DATA, 1'b0, 1'b0, 1'b1, 24'd0);
    offer(KIND_RX, FT_CTS, 1'b0, 1'b0, 1'b0, 24'd777);
    offer(KIND_DONE, FT_DATA, 1'b0, 1'b0, 1'b0, 24'd0);
    offer(KIND_RX, FT_ACK, 1'b0, 1'b0, 1'b0, 24'd0);
    quiesce();

    for (int p = 0; p < 5; p++) begin
      settle_exchange();
      quiesce();
      write_reg(REG_FIXED_TIMEOUT, {8'd0, fix_tab[p]});
      write_reg(REG_NOTIFIER, {31'd0, notif_tab[p]});
      write_reg(REG_RETRY_LIMIT, {28'd0, lim_tab[p]});
      settings_used++;
      in_steady = (p == 1);
      out_steady = (p == 3);
      for (int i = 0; i < PHASE_EVENTS; i++) begin
        if (p == 2 && i == 10) begin
          in_steady = 1'b1;
          long_hold_req = 1'b1;
        end
        if (p == 2 && i == 30) in_steady = 1'b0;
        offer_event(pick_event());
      end
    end
    quiesce();

    $display("summary: %0d events over %0d register settings, %0d result beats checked",
             sb.events_seen, settings_used, sb.beats_seen);
    $display("summary: %0d mismatches, %0d beats still owed", sb.errors,
             sb.owed_beats.size());
    if (sb.errors == 0 && sb.owed_beats.size() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
